FILE: hw/rtl/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared types and constants of the paged memory mapper: bus decode
// constants, memory sizes, result target codes and the control structs that
// pass between the mapper's sub-blocks.
// ----------------------------------------------------------------------------
package pmm_pkg;

    // sizes
    localparam int ROM_PAGES       = 64;
    localparam int SYS_RAM_BYTES   = 8192;
    localparam int CART_BANK_BYTES = 16384;
    localparam int CART_RAM_BYTES  = 2 * CART_BANK_BYTES;
    localparam int SYS_AW          = $clog2(SYS_RAM_BYTES);
    localparam int CART_AW         = $clog2(CART_RAM_BYTES);
    localparam int PAGE_W          = 6;
    localparam int OFFSET_W        = 14;
    localparam int ROM_AW          = PAGE_W + OFFSET_W;
    localparam int BUS_AW          = 16;
    localparam int DATA_W          = 8;
    localparam int PAGE_TBL_DEPTH  = 2 ** PAGE_W;

    // bus addresses
    localparam logic [BUS_AW-1:0] LOW_KB_LIMIT  = 16'h0400;
    localparam logic [BUS_AW-1:0] PAGE_REG_BASE = 16'hFFFC;
    localparam logic [BUS_AW-1:0] ALT_SLOT0_ADR = 16'h0000;
    localparam logic [BUS_AW-1:0] ALT_SLOT1_ADR = 16'h4000;
    localparam logic [BUS_AW-1:0] ALT_SLOT2_ADR = 16'h8000;

    // regions of the bus (address bits 15:14)
    localparam logic [1:0] REGION_SLOT0 = 2'd0;
    localparam logic [1:0] REGION_SLOT1 = 2'd1;
    localparam logic [1:0] REGION_SLOT2 = 2'd2;
    localparam logic [1:0] REGION_SYS   = 2'd3;

    // paging control bytes at the top of system ram (index bits 1:0)
    localparam logic [1:0] CTL_BYTE   = 2'd0;
    localparam logic [1:0] SLOT0_BYTE = 2'd1;
    localparam logic [1:0] SLOT1_BYTE = 2'd2;
    localparam logic [1:0] SLOT2_BYTE = 2'd3;
    localparam int         CTL_EN_BIT   = 3;
    localparam int         CTL_BANK_BIT = 2;

    // reset contents of the paging bytes
    localparam logic [PAGE_W-1:0] SLOT0_INIT = 6'd0;
    localparam logic [PAGE_W-1:0] SLOT1_INIT = 6'd1;
    localparam logic [PAGE_W-1:0] SLOT2_INIT = 6'd2;
    localparam logic [SYS_AW-1:0] SLOT1_BYTE_IDX = 13'h1FFE;
    localparam logic [SYS_AW-1:0] SLOT2_BYTE_IDX = 13'h1FFF;

    // result target codes
    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_CART = 2'd1,
        TGT_SYS  = 2'd2,
        TGT_NONE = 2'd3
    } target_t;

    // clear sequencer states
    typedef enum logic {
        INIT_CLEAR,
        INIT_RUN
    } init_state_t;

    // clear sequencer to memories
    typedef struct packed {
        logic               busy;
        logic               sys_we;
        logic [SYS_AW-1:0]  sys_addr;
        logic [DATA_W-1:0]  sys_data;
        logic               cart_we;
        logic [CART_AW-1:0] cart_addr;
    } init_ctl_t;

    // decoded access of one item
    typedef struct packed {
        logic               sys_we;
        logic               sys_re;
        logic [SYS_AW-1:0]  sys_addr;
        logic               cart_we;
        logic               cart_re;
        logic [CART_AW-1:0] cart_addr;
        logic [DATA_W-1:0]  wdata;
        target_t            target;
        logic [ROM_AW-1:0]  rom_address;
    } access_t;

endpackage

FILE: hw/rtl/pmm_ram.sv
// ----------------------------------------------------------------------------
// pmm_ram
// Generic synchronous RAM: one write port, one read port with read enable,
// read data registered (held while not reading).
// ----------------------------------------------------------------------------
module pmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/pmm_init.sv
// ----------------------------------------------------------------------------
// pmm_init
// Clearing pass after reset: sweeps cartridge ram and system ram one entry
// a cycle, loading the reset values of the paging bytes into system ram.
// ----------------------------------------------------------------------------
module pmm_init (
    input  logic               aclk,
    input  logic               aresetn,
    output pmm_pkg::init_ctl_t init_ctl
);
    import pmm_pkg::*;

    init_state_t        state_reg, state_next;
    logic [CART_AW-1:0] cnt_reg, cnt_next;
    logic [SYS_AW-1:0]  sys_idx;

    // state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= INIT_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign sys_idx = cnt_reg[SYS_AW-1:0];

    // next state and memory writes
    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        init_ctl           = '0;
        init_ctl.sys_addr  = sys_idx;
        init_ctl.cart_addr = cnt_reg;
        case (state_reg)
            INIT_CLEAR: begin
                init_ctl.busy    = 1'b1;
                init_ctl.cart_we = 1'b1;
                // system ram is the lower part of the sweep
                init_ctl.sys_we  = (cnt_reg < CART_AW'(SYS_RAM_BYTES));
                if (sys_idx == SLOT1_BYTE_IDX) begin
                    init_ctl.sys_data = DATA_W'(SLOT1_INIT);
                end else if (sys_idx == SLOT2_BYTE_IDX) begin
                    init_ctl.sys_data = DATA_W'(SLOT2_INIT);
                end else begin
                    init_ctl.sys_data = '0;
                end
                cnt_next = cnt_reg + 1'b1;
                if (&cnt_reg) begin
                    state_next = INIT_RUN;
                end
            end
            INIT_RUN: begin
                cnt_next = cnt_reg;
            end
            default: begin
                state_next = INIT_CLEAR;
            end
        endcase
    end

    // sweep runs only until the last entry
    a_run_counter_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == INIT_RUN |=> $stable(cnt_reg))
        else $error("sweep counter moved after clearing");
    a_clear_to_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == INIT_CLEAR && !(&cnt_reg) |=> state_reg == INIT_CLEAR)
        else $error("clearing ended early");
    a_sys_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        init_ctl.sys_we |-> init_ctl.busy && cnt_reg[CART_AW-1:SYS_AW] == '0)
        else $error("system ram clear out of range");

endmodule

FILE: hw/rtl/pmm_decode.sv
// ----------------------------------------------------------------------------
// pmm_decode
// Page registers and bus decode: maps one access to a ROM address, a RAM
// access or no target, and updates the slot pages and cartridge ram control
// on writes.
module pmm_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          alt_mode,
    input  logic                          accept,
    input  logic                          command,
    input  logic [pmm_pkg::BUS_AW-1:0]    address,
    input  logic [pmm_pkg::DATA_W-1:0]    write_data,
    output pmm_pkg::access_t              access
);
    import pmm_pkg::*;

    logic [PAGE_W-1:0] slot0_reg, slot0_next;
    logic [PAGE_W-1:0] slot1_reg, slot1_next;
    logic [PAGE_W-1:0] slot2_reg, slot2_next;
    logic              cart_en_reg, cart_en_next;
    logic              cart_bank_reg, cart_bank_next;
    // copies of the paging bytes held in system ram
    logic [PAGE_W-1:0] sh_p0_reg, sh_p0_next;
    logic [PAGE_W-1:0] sh_p1_reg, sh_p1_next;
    logic [PAGE_W-1:0] sh_p2_reg, sh_p2_next;
    logic              sh_en_reg, sh_en_next;
    logic              sh_bank_reg, sh_bank_next;

    logic [PAGE_W-1:0] page_mod [PAGE_TBL_DEPTH];
    logic [PAGE_W-1:0] rd_page;
    logic [1:0]        region;
    logic              cart_on;
    logic              ctl_hit;
    logic [PAGE_W-1:0] wr_page;

    // page number reduced modulo the rom size
    for (genvar i = 0; i < PAGE_TBL_DEPTH; i++) begin : g_page_mod
        assign page_mod[i] = PAGE_W'(i % ROM_PAGES);
    end

    assign region  = address[BUS_AW-1:BUS_AW-2];
    assign cart_on = cart_en_reg && !alt_mode;
    assign ctl_hit = (region == REGION_SYS) && (&address[SYS_AW-1:2]);
    assign wr_page = write_data[PAGE_W-1:0];

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot0_reg     <= SLOT0_INIT;
            slot1_reg     <= SLOT1_INIT;
            slot2_reg     <= SLOT2_INIT;
            cart_en_reg   <= 1'b0;
            cart_bank_reg <= 1'b0;
            sh_p0_reg     <= SLOT0_INIT;
            sh_p1_reg     <= SLOT1_INIT;
            sh_p2_reg     <= SLOT2_INIT;
            sh_en_reg     <= 1'b0;
            sh_bank_reg   <= 1'b0;
        end else begin
            slot0_reg     <= slot0_next;
            slot1_reg     <= slot1_next;
            slot2_reg     <= slot2_next;
            cart_en_reg   <= cart_en_next;
            cart_bank_reg <= cart_bank_next;
            sh_p0_reg     <= sh_p0_next;
            sh_p1_reg     <= sh_p1_next;
            sh_p2_reg     <= sh_p2_next;
            sh_en_reg     <= sh_en_next;
            sh_bank_reg   <= sh_bank_next;
        end
    end

    // paging byte copies follow every system ram write to them
    always_comb begin
        sh_p0_next   = sh_p0_reg;
        sh_p1_next   = sh_p1_reg;
        sh_p2_next   = sh_p2_reg;
        sh_en_next   = sh_en_reg;
        sh_bank_next = sh_bank_reg;
        if (accept && command && ctl_hit) begin
            case (address[1:0])
                CTL_BYTE: begin
                    sh_en_next   = write_data[CTL_EN_BIT];
                    sh_bank_next = write_data[CTL_BANK_BIT];
                end
                SLOT0_BYTE: sh_p0_next = wr_page;
                SLOT1_BYTE: sh_p1_next = wr_page;
                SLOT2_BYTE: sh_p2_next = wr_page;
                default:    sh_p0_next = sh_p0_reg;
            endcase
        end
    end

    // page register updates
    always_comb begin
        slot0_next     = slot0_reg;
        slot1_next     = slot1_reg;
        slot2_next     = slot2_reg;
        cart_en_next   = cart_en_reg;
        cart_bank_next = cart_bank_reg;
        if (accept && command) begin
            if (alt_mode) begin
                if (address == ALT_SLOT0_ADR) begin
                    slot0_next = wr_page;
                end else if (address == ALT_SLOT1_ADR) begin
                    slot1_next = wr_page;
                end else if (address == ALT_SLOT2_ADR) begin
                    slot2_next = wr_page;
                end
            end else if (address >= PAGE_REG_BASE) begin
                // reload everything from the paging bytes, this write included
                slot0_next     = sh_p0_next;
                slot1_next     = sh_p1_next;
                slot2_next     = sh_p2_next;
                cart_en_next   = sh_en_next;
                cart_bank_next = sh_bank_next;
            end
        end
    end

    // access decode
    always_comb begin
        access             = '0;
        access.sys_addr    = address[SYS_AW-1:0];
        access.cart_addr   = {cart_bank_reg, address[OFFSET_W-1:0]};
        access.wdata       = write_data;
        access.target      = TGT_NONE;
        rd_page            = '0;
        if (!command) begin
            if (!alt_mode && address < LOW_KB_LIMIT) begin
                access.target = TGT_ROM;
                rd_page       = '0;
            end else begin
                case (region)
                    REGION_SLOT0: begin
                        access.target = TGT_ROM;
                        rd_page       = slot0_reg;
                    end
                    REGION_SLOT1: begin
                        access.target = TGT_ROM;
                        rd_page       = slot1_reg;
                    end
                    REGION_SLOT2: begin
                        if (cart_on) begin
                            access.target  = TGT_CART;
                            access.cart_re = accept;
                        end else begin
                            access.target = TGT_ROM;
                            rd_page       = slot2_reg;
                        end
                    end
                    default: begin
                        access.target = TGT_SYS;
                        access.sys_re = accept;
                    end
                endcase
            end
        end else begin
            if (region == REGION_SLOT2 && cart_on) begin
                access.target  = TGT_CART;
                access.cart_we = accept;
            end else if (region == REGION_SYS) begin
                access.target = TGT_SYS;
                access.sys_we = accept;
            end
        end
        if (access.target == TGT_ROM) begin
            access.rom_address = {page_mod[rd_page], address[OFFSET_W-1:0]};
        end
    end

    // alternate mode never reaches cartridge ram
    a_alt_no_cart: assert property (@(posedge aclk) disable iff (!aresetn)
        alt_mode |-> !access.cart_we && !access.cart_re)
        else $error("cartridge ram used in alternate mode");
    // a reload in standard mode leaves the slots equal to the byte copies
    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && command && !alt_mode && address >= PAGE_REG_BASE
        |=> slot0_reg == sh_p0_reg && slot1_reg == sh_p1_reg
            && slot2_reg == sh_p2_reg && cart_en_reg == sh_en_reg)
        else $error("page registers differ from paging bytes after reload");
    a_page_regs_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(slot0_reg) && $stable(slot1_reg) && $stable(slot2_reg))
        else $error("page register changed without an item");

endmodule

FILE: hw/rtl/paged_memory_mapper.sv
// ----------------------------------------------------------------------------
// paged_memory_mapper
// Maps byte accesses of a 16-bit CPU bus onto paged ROM, cartridge ram and
// system ram, and keeps the paging registers.
// ----------------------------------------------------------------------------
// One item is taken per cycle unless clearing runs or a result stalls; its
// result appears in the next cycle. The output stage holds a stalled result
// and a new item is taken in the same cycle the result is taken. After reset
// a clearing pass writes both rams (cartridge ram swept in full, system ram
// in its first 8192 steps); no item is taken until it ends. alt_cart_mode is
// to be written by the user only while idle; the block does not enforce it.
module paged_memory_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // alt_cart_mode
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [0] command, [16:1] address, [24:17] write_data
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata         // [1:0] target, [21:2] rom_address, [29:22] read_data
);
    import pmm_pkg::*;

    logic              alt_mode_reg;
    logic              out_valid_reg;
    target_t           target_reg;
    logic [ROM_AW-1:0] rom_reg;
    logic              rd_en_reg;

    init_ctl_t         init_ctl;
    access_t           access;
    logic              accept;
    logic [DATA_W-1:0] sys_rdata;
    logic [DATA_W-1:0] cart_rdata;
    logic [DATA_W-1:0] read_data;

    logic               sys_we;
    logic [SYS_AW-1:0]  sys_waddr;
    logic [DATA_W-1:0]  sys_wdata;
    logic               cart_we;
    logic [CART_AW-1:0] cart_waddr;
    logic [DATA_W-1:0]  cart_wdata;

    assign s_tready = !init_ctl.busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            alt_mode_reg <= cfg_wdata;
        end
    end

    // clearing pass
    pmm_init u_init (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init_ctl (init_ctl)
    );

    // page registers and decode
    pmm_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .alt_mode   (alt_mode_reg),
        .accept     (accept),
        .command    (s_tdata[0]),
        .address    (s_tdata[16:1]),
        .write_data (s_tdata[24:17]),
        .access     (access)
    );

    // ram write ports: clearing pass or item
    always_comb begin
        if (init_ctl.busy) begin
            sys_we     = init_ctl.sys_we;
            sys_waddr  = init_ctl.sys_addr;
            sys_wdata  = init_ctl.sys_data;
            cart_we    = init_ctl.cart_we;
            cart_waddr = init_ctl.cart_addr;
            cart_wdata = '0;
        end else begin
            sys_we     = access.sys_we;
            sys_waddr  = access.sys_addr;
            sys_wdata  = access.wdata;
            cart_we    = access.cart_we;
            cart_waddr = access.cart_addr;
            cart_wdata = access.wdata;
        end
    end

    pmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SYS_RAM_BYTES)
    ) u_sys_ram (
        .aclk  (aclk),
        .we    (sys_we),
        .waddr (sys_waddr),
        .wdata (sys_wdata),
        .re    (access.sys_re),
        .raddr (access.sys_addr),
        .rdata (sys_rdata)
    );

    pmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CART_RAM_BYTES)
    ) u_cart_ram (
        .aclk  (aclk),
        .we    (cart_we),
        .waddr (cart_waddr),
        .wdata (cart_wdata),
        .re    (access.cart_re),
        .raddr (access.cart_addr),
        .rdata (cart_rdata)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            target_reg <= access.target;
            rom_reg    <= access.rom_address;
            rd_en_reg  <= access.sys_re || access.cart_re;
        end
    end

    // ram data only on reads of a ram
    always_comb begin
        read_data = '0;
        if (rd_en_reg) begin
            read_data = (target_reg == TGT_SYS) ? sys_rdata : cart_rdata;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, read_data, rom_reg, target_reg};

    // every item gives a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item gave no result");
    a_rom_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == TGT_ROM |-> m_tdata[29:22] == '0)
        else $error("rom result carries ram data");
    a_ram_no_rom_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != TGT_ROM |-> m_tdata[21:2] == '0)
        else $error("non-rom result carries a rom address");
    a_no_item_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        init_ctl.busy |-> !access.sys_we && !access.cart_we && !m_tvalid)
        else $error("item handled during clearing pass");

endmodule
